// ===== hw/rtl/pvdd_pkg.sv =====
// shared types and constants for the postings varint delta decoder
`timescale 1ns / 1ps

package pvdd_pkg;

  // parser phase codes
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_DELTA  = 3'd1,
    PH_SCORE  = 3'd2,
    PH_IDLEN  = 3'd3,
    PH_IDBYTE = 3'd4,
    PH_DRAIN  = 3'd5
  } phase_t;

  // result kind codes
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_IDBYTE = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // end status codes
  localparam logic [1:0] ST_CLEAN     = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_SHORT_HDR = 2'd2;

  // varint limits
  localparam logic [2:0] LAST_GROUP   = 3'd4;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] doc_hash;
    logic [31:0] score_bits;
    logic [15:0] id_length;
    logic [7:0]  id_byte;
    logic        posting_done;
    logic        end_of_list;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== hw/rtl/postings_varint_delta_decoder.sv =====
// postings buffer parser: count header, varint deltas, scores, id lengths and id bytes
// a result is registered in the output register, or in the skid register while the output is held
// throughput: one byte per cycle, sustained while the result side takes items
// a one-item skid register keeps input open while a result waits, until a second result comes
// reset: rst is synchronous; clears the parser to the header phase and empties both
// result registers; the last byte of a buffer also returns the parser to that state
`timescale 1ns / 1ps

module postings_varint_delta_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] doc_hash, [63:32] score_bits, [79:64] id_length,
                                 // [87:80] id_byte, [88] posting_done, [90:89] status
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // end_of_list
);

  // parser state
  pvdd_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_idx, byte_idx_next;
  logic [31:0] postings_left, postings_left_next;
  logic [31:0] delta_accum, delta_accum_next;
  logic [2:0]  delta_group, delta_group_next;
  logic [31:0] running_hash, running_hash_next;
  logic [31:0] score_reg, score_reg_next;
  logic [15:0] id_len_reg, id_len_reg_next;
  logic [15:0] id_bytes_left, id_bytes_left_next;

  // result registers
  pvdd_pkg::result_t out_item, skid_item, res;
  logic              skid_valid;
  logic              has_res;
  logic              accept;

  // scratch values
  logic [31:0] delta_bits;
  logic [31:0] delta_word;
  logic [15:0] id_len_full;
  logic [15:0] id_left_dec;
  logic [31:0] postings_dec;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // place the payload bits of this varint byte: seven per group, four in the last group
  always_comb begin
    case (delta_group)
      3'd0:    delta_bits = {25'd0, s_tdata[6:0]};
      3'd1:    delta_bits = {18'd0, s_tdata[6:0], 7'd0};
      3'd2:    delta_bits = {11'd0, s_tdata[6:0], 14'd0};
      3'd3:    delta_bits = {4'd0, s_tdata[6:0], 21'd0};
      default: delta_bits = {s_tdata[3:0], 28'd0};
    endcase
  end

  assign delta_word   = delta_accum | delta_bits;
  assign id_len_full  = {s_tdata, id_len_reg[7:0]};
  assign id_left_dec  = id_bytes_left - 16'd1;
  assign postings_dec = postings_left - 32'd1;

  // next parser state and result for the byte at the input
  always_comb begin
    phase_next         = phase;
    byte_idx_next      = byte_idx;
    postings_left_next = postings_left;
    delta_accum_next   = delta_accum;
    delta_group_next   = delta_group;
    running_hash_next  = running_hash;
    score_reg_next     = score_reg;
    id_len_reg_next    = id_len_reg;
    id_bytes_left_next = id_bytes_left;
    has_res            = 1'b0;
    res                = '0;

    unique case (phase)
      pvdd_pkg::PH_HEADER: begin
        postings_left_next = {s_tdata, postings_left[31:8]};
        byte_idx_next      = byte_idx + 2'd1;
        if (byte_idx == 2'd3) begin
          byte_idx_next = 2'd0;
          phase_next    = (postings_left_next != 32'd0) ? pvdd_pkg::PH_DELTA
                                                        : pvdd_pkg::PH_DRAIN;
        end
      end
      pvdd_pkg::PH_DELTA: begin
        if (!s_tdata[7] || delta_group == pvdd_pkg::LAST_GROUP) begin
          running_hash_next = running_hash + delta_word;
          delta_accum_next  = 32'd0;
          delta_group_next  = 3'd0;
          byte_idx_next     = 2'd0;
          phase_next        = pvdd_pkg::PH_SCORE;
        end else begin
          delta_accum_next = delta_word;
          delta_group_next = delta_group + 3'd1;
        end
      end
      pvdd_pkg::PH_SCORE: begin
        score_reg_next = {s_tdata, score_reg[31:8]};
        byte_idx_next  = byte_idx + 2'd1;
        if (byte_idx == 2'd3) begin
          byte_idx_next = 2'd0;
          phase_next    = pvdd_pkg::PH_IDLEN;
        end
      end
      pvdd_pkg::PH_IDLEN: begin
        if (byte_idx == 2'd0) begin
          id_len_reg_next = {8'd0, s_tdata};
          byte_idx_next   = 2'd1;
        end else begin
          id_len_reg_next    = id_len_full;
          id_bytes_left_next = id_len_full;
          byte_idx_next      = 2'd0;
          has_res            = 1'b1;
          res.kind           = pvdd_pkg::KIND_HEADER;
          res.doc_hash       = running_hash;
          res.score_bits     = score_reg;
          res.id_length      = id_len_full;
          if (id_len_full == 16'd0) begin
            // empty id closes the posting at once
            res.posting_done   = 1'b1;
            postings_left_next = postings_dec;
            phase_next         = (postings_dec != 32'd0) ? pvdd_pkg::PH_DELTA
                                                         : pvdd_pkg::PH_DRAIN;
          end else begin
            phase_next = pvdd_pkg::PH_IDBYTE;
          end
        end
      end
      pvdd_pkg::PH_IDBYTE: begin
        has_res            = 1'b1;
        res.kind           = pvdd_pkg::KIND_IDBYTE;
        res.doc_hash       = running_hash;
        res.score_bits     = score_reg;
        res.id_length      = id_len_reg;
        res.id_byte        = s_tdata;
        id_bytes_left_next = id_left_dec;
        if (id_left_dec == 16'd0) begin
          res.posting_done   = 1'b1;
          postings_left_next = postings_dec;
          byte_idx_next      = 2'd0;
          phase_next         = (postings_dec != 32'd0) ? pvdd_pkg::PH_DELTA
                                                       : pvdd_pkg::PH_DRAIN;
        end
      end
      default: begin
      end
    endcase

    // end of buffer: report status and fall back to the reset state
    if (s_tlast) begin
      if (phase_next == pvdd_pkg::PH_HEADER) begin
        res.status = pvdd_pkg::ST_SHORT_HDR;
      end else if (phase_next == pvdd_pkg::PH_SCORE || phase_next == pvdd_pkg::PH_IDLEN ||
                   phase_next == pvdd_pkg::PH_IDBYTE ||
                   (phase_next == pvdd_pkg::PH_DELTA && delta_group_next != 3'd0)) begin
        res.status = pvdd_pkg::ST_TRUNCATED;
      end else begin
        res.status = pvdd_pkg::ST_CLEAN;
      end
      if (!has_res) begin
        res.kind = pvdd_pkg::KIND_END;
      end
      has_res            = 1'b1;
      res.end_of_list    = 1'b1;
      phase_next         = pvdd_pkg::PH_HEADER;
      byte_idx_next      = 2'd0;
      postings_left_next = 32'd0;
      delta_accum_next   = 32'd0;
      delta_group_next   = 3'd0;
      running_hash_next  = 32'd0;
      score_reg_next     = 32'd0;
      id_len_reg_next    = 16'd0;
      id_bytes_left_next = 16'd0;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= pvdd_pkg::PH_HEADER;
      byte_idx      <= 2'd0;
      postings_left <= 32'd0;
      delta_accum   <= 32'd0;
      delta_group   <= 3'd0;
      running_hash  <= 32'd0;
      score_reg     <= 32'd0;
      id_len_reg    <= 16'd0;
      id_bytes_left <= 16'd0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_idx      <= byte_idx_next;
      postings_left <= postings_left_next;
      delta_accum   <= delta_accum_next;
      delta_group   <= delta_group_next;
      running_hash  <= running_hash_next;
      score_reg     <= score_reg_next;
      id_len_reg    <= id_len_reg_next;
      id_bytes_left <= id_bytes_left_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (accept && has_res) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      m_tvalid   <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      m_tvalid <= accept && has_res;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (accept && has_res) begin
        skid_item <= res;
      end
    end else if (skid_valid) begin
      out_item <= skid_item;
    end else begin
      out_item <= res;
    end
  end

  assign m_tdata = {5'd0, out_item.status, out_item.posting_done, out_item.id_byte,
                    out_item.id_length, out_item.score_bits, out_item.doc_hash};
  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.end_of_list;

`ifndef SYNTHESIS
  // skid entry is only used behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry valid with empty output register");

  // varint never runs past five groups
  a_group_range: assert property (@(posedge clk) disable iff (rst)
    delta_group <= pvdd_pkg::LAST_GROUP)
    else $error("varint group count out of range");

  // id byte phase always has bytes left to take
  a_id_left: assert property (@(posedge clk) disable iff (rst)
    (phase == pvdd_pkg::PH_IDBYTE) |-> (id_bytes_left != 16'd0))
    else $error("id byte phase with no bytes left");

  // last byte returns the parser to a clean header phase
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (phase == pvdd_pkg::PH_HEADER && postings_left == 32'd0 &&
                             running_hash == 32'd0))
    else $error("parser not cleared after last byte");

  // hash stays clear while the count header is read
  a_header_hash: assert property (@(posedge clk) disable iff (rst)
    (phase == pvdd_pkg::PH_HEADER) |-> (running_hash == 32'd0 && delta_accum == 32'd0))
    else $error("hash not clear in header phase");
`endif

endmodule

// ===== bench/postings_varint_delta_decoder_tb.sv =====
// testbench for the postings decoder: framed byte buffers in, scoreboard checks every result
`timescale 1ns / 1ps

module postings_varint_delta_decoder_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_BYTES = 750;
  localparam int HOLD_CYCLES  = 300;

  // tracks the parser state and holds the results still owed by the block
  class postings_scoreboard;
    pvdd_pkg::phase_t  phase;
    logic [2:0]        byte_idx;
    logic [31:0]       postings_left;
    logic [31:0]       delta_accum;
    logic [5:0]        delta_shift;
    logic [31:0]       running_hash;
    logic [31:0]       score_word;
    logic [15:0]       id_len;
    logic [15:0]       id_left;
    pvdd_pkg::result_t owed_q[$];
    int failures;
    int parsed_bytes;
    int headers;
    int id_bytes;
    int end_markers;
    int truncated;
    int short_hdr;

    function void clear_parser();
      phase         = pvdd_pkg::PH_HEADER;
      byte_idx      = '0;
      postings_left = '0;
      delta_accum   = '0;
      delta_shift   = '0;
      running_hash  = '0;
      score_word    = '0;
      id_len        = '0;
      id_left       = '0;
    endfunction

    function void close_posting();
      postings_left = postings_left - 32'd1;
      phase    = (postings_left != 0) ? pvdd_pkg::PH_DELTA : pvdd_pkg::PH_DRAIN;
      byte_idx = '0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function string fmt(pvdd_pkg::result_t r);
      return $sformatf("kind=%0d hash=%h score=%h len=%0d id=%h done=%b eol=%b st=%0d",
                       r.kind, r.doc_hash, r.score_bits, r.id_length, r.id_byte,
                       r.posting_done, r.end_of_list, r.status);
    endfunction

    // one accepted byte: advance the parser and queue the result it owes
    function void note_byte(logic [7:0] b, logic last);
      pvdd_pkg::result_t r;
      bit                emit;
      logic [1:0]        st;
      r    = '0;
      emit = 1'b0;
      st   = pvdd_pkg::ST_CLEAN;
      if (phase != pvdd_pkg::PH_DRAIN) parsed_bytes++;
      case (phase)
        pvdd_pkg::PH_HEADER: begin
          postings_left = {b, postings_left[31:8]};
          byte_idx = byte_idx + 3'd1;
          if (byte_idx >= 3'd4) begin
            byte_idx = '0;
            phase = (postings_left != 0) ? pvdd_pkg::PH_DELTA : pvdd_pkg::PH_DRAIN;
          end
        end
        pvdd_pkg::PH_DELTA: begin
          delta_accum = delta_accum | (32'(b[6:0]) << delta_shift);
          if (!b[7] || delta_shift >= 6'd28) begin
            running_hash = running_hash + delta_accum;
            delta_accum  = '0;
            delta_shift  = '0;
            byte_idx     = '0;
            phase        = pvdd_pkg::PH_SCORE;
          end else begin
            delta_shift = delta_shift + 6'd7;
          end
        end
        pvdd_pkg::PH_SCORE: begin
          score_word = {b, score_word[31:8]};
          byte_idx = byte_idx + 3'd1;
          if (byte_idx >= 3'd4) begin
            byte_idx = '0;
            phase = pvdd_pkg::PH_IDLEN;
          end
        end
        pvdd_pkg::PH_IDLEN: begin
          if (byte_idx == 3'd0) begin
            id_len   = {8'h00, b};
            byte_idx = 3'd1;
          end else begin
            id_len      = {b, id_len[7:0]};
            byte_idx    = '0;
            id_left     = id_len;
            emit        = 1'b1;
            r.kind      = pvdd_pkg::KIND_HEADER;
            r.doc_hash  = running_hash;
            r.score_bits = score_word;
            r.id_length = id_len;
            if (id_len == 0) begin
              r.posting_done = 1'b1;
              close_posting();
            end else begin
              phase = pvdd_pkg::PH_IDBYTE;
            end
          end
        end
        pvdd_pkg::PH_IDBYTE: begin
          emit         = 1'b1;
          r.kind       = pvdd_pkg::KIND_IDBYTE;
          r.doc_hash   = running_hash;
          r.score_bits = score_word;
          r.id_length  = id_len;
          r.id_byte    = b;
          id_left      = id_left - 16'd1;
          if (id_left == 0) begin
            r.posting_done = 1'b1;
            close_posting();
          end
        end
        default: ;
      endcase

      // last byte: status from where the parser stopped, marker if nothing else came out
      if (last) begin
        case (phase) inside
          pvdd_pkg::PH_HEADER: st = pvdd_pkg::ST_SHORT_HDR;
          pvdd_pkg::PH_SCORE, pvdd_pkg::PH_IDLEN, pvdd_pkg::PH_IDBYTE:
            st = pvdd_pkg::ST_TRUNCATED;
          pvdd_pkg::PH_DELTA:
            st = (delta_shift != 0) ? pvdd_pkg::ST_TRUNCATED : pvdd_pkg::ST_CLEAN;
          default: st = pvdd_pkg::ST_CLEAN;
        endcase
        if (!emit) begin
          emit   = 1'b1;
          r      = '0;
          r.kind = pvdd_pkg::KIND_END;
        end
        r.status      = st;
        r.end_of_list = 1'b1;
        clear_parser();
      end
      if (emit) owed_q.insert(owed_q.size(), r);
    endfunction

    // one accepted result: compare with the oldest owed one
    function void check_result(logic [95:0] d, logic [1:0] u, logic l);
      pvdd_pkg::result_t got;
      pvdd_pkg::result_t want;
      got.kind         = u;
      got.doc_hash     = d[31:0];
      got.score_bits   = d[63:32];
      got.id_length    = d[79:64];
      got.id_byte      = d[87:80];
      got.posting_done = d[88];
      got.status       = d[90:89];
      got.end_of_list  = l;
      if (d[95:91] !== 5'd0) flag($sformatf("pad bits of result not zero: %h", d[95:91]));
      if (owed_q.size() == 0) begin
        flag({"result with nothing owed: ", fmt(got)});
      end else begin
        want = owed_q.pop_front();
        if (got !== want) begin
          flag({"result mismatch, expected: ", fmt(want)});
          if (failures <= 10) $display("                    got: %s", fmt(got));
        end
        if (want.kind == pvdd_pkg::KIND_HEADER) headers++;
        if (want.kind == pvdd_pkg::KIND_IDBYTE) id_bytes++;
        if (want.kind == pvdd_pkg::KIND_END) end_markers++;
        if (want.end_of_list && want.status == pvdd_pkg::ST_TRUNCATED) truncated++;
        if (want.end_of_list && want.status == pvdd_pkg::ST_SHORT_HDR) short_hdr++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  postings_scoreboard sb;
  logic [7:0] frame_q[$];
  bit  steady    = 1'b0;
  bit  hold_req  = 1'b0;
  int  frames    = 0;
  int  cycle_cnt = 0;

  postings_varint_delta_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // append one byte to the buffer being built
  function automatic void add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  // little-endian field of n bytes
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endtask

  // varint of exactly n bytes; a fifth byte gets a random top bit and junk high bits
  task automatic put_varint(input logic [31:0] v, input int n);
    logic [7:0] g;
    for (int i = 0; i < n; i++) begin
      g = 8'((v >> (7 * i)) & 32'h7F);
      if (i == 4) g = {1'($urandom), 3'($urandom), v[31:28]};
      else g[7] = (i < n - 1);
      add_byte(g);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!steady) begin
      while ($urandom_range(0, 99) < 29) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, last);
  endtask

  // send the queued bytes as one buffer, last flag on the final one
  task automatic send_frame();
    int sz;
    sz = frame_q.size();
    for (int i = 0; i < sz; i++) send_byte(frame_q[i], i == sz - 1);
    frame_q.delete();
    frames++;
  endtask

  // mostly well-formed buffers with random content, some cut short, some noise
  task automatic random_frame();
    int sel;
    int k;
    int idl;
    int len;
    logic [31:0] cnt;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      len = $urandom_range(1, 8);
      repeat (len) add_byte(8'($urandom));
    end else begin
      if (sel < 13) begin
        cnt = 0;
        k = 0;
      end else if (sel < 28) begin
        cnt = $urandom_range(32'hFFFFFFFF, 5);
        k = $urandom_range(1, 3);
      end else begin
        cnt = $urandom_range(1, 4);
        k = cnt;
      end
      put_le(cnt, 4);
      repeat (k) begin
        put_varint($urandom, $urandom_range(1, 5));
        put_le($urandom, 4);
        idl = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 4) : $urandom_range(5, 12);
        put_le(idl, 2);
        repeat (idl) add_byte(8'($urandom));
      end
      // bytes past the counted postings
      if (k == cnt && $urandom_range(0, 99) < 25)
        repeat ($urandom_range(1, 2)) add_byte(8'($urandom));
      if ($urandom_range(0, 99) < 30) begin
        len = $urandom_range(1, frame_q.size());
        while (frame_q.size() > len) void'(frame_q.pop_back());
      end
    end
    send_frame();
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 29);
      end
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  // stimulus and verdict
  initial begin
    sb = new;
    sb.clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // count header cut after one byte
    add_byte(8'h11);
    send_frame();
    // zero count, the byte after it is ignored
    put_le(32'd0, 4);
    add_byte(8'hAB);
    send_frame();
    // widest delta and score, empty id; the header closes the buffer cleanly
    put_le(32'd1, 4);
    repeat (5) add_byte(8'hFF);
    put_le(32'hFFFF_FFFF, 4);
    put_le(32'd0, 2);
    send_frame();
    // widest id length, buffer ends on the header so the posting is partial
    put_le(32'd2, 4);
    add_byte(8'h00);
    put_le(32'd0, 4);
    put_le(32'hFFFF, 2);
    send_frame();

    // random buffers, one long output hold and one stretch without gaps
    while (sb.parsed_bytes < TARGET_BYTES) begin
      if (frames == 12) hold_req = 1'b1;
      steady = (sb.parsed_bytes > 350 && sb.parsed_bytes < 480);
      random_frame();
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.owed_q.size() != 0) sb.flag("results still owed at the end");

    $display("covered %0d buffers, %0d parsed bytes: %0d posting headers, %0d id bytes",
             frames, sb.parsed_bytes, sb.headers, sb.id_bytes);
    $display("%0d end markers, %0d truncated postings, %0d short count headers",
             sb.end_markers, sb.truncated, sb.short_hdr);
    if (sb.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures", sb.failures);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
